/* sv/orb_pkg.sv */
package orb_pkg;

    // Action codes of an input request
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // Register map (index taken from paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity register
    localparam int          CAP_W     = 7;
    localparam logic [6:0]  CAP_RESET = 7'd64;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_APP  = 4'b0010,
        ST_OLD  = 4'b0100,
        ST_LIST = 4'b1000
    } t_state;

endpackage

/* sv/overwriting_ring_buffer.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------
// request   | start & !busy          | i_action, i_entry_value
// result    | o_strobe (one cycle)   | o_listed_value, o_is_last
// config    | psel&penable&pwrite    | paddr, pwdata (read: prdata)
//
// Append goes through ST_APP, plus ST_OLD on a full ring (second pass of the
// shared index unit moves the oldest index). Remove goes through ST_OLD unless
// it takes the only entry. List: one memory read per cycle in ST_LIST, each
// result in the cycle after its read. busy is high while the sequencer works.
// Reset is synchronous, active low, and empties the ring; capacity goes to 64.
// The receiver cannot stall: every strobe is a delivered result.
module overwriting_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_entry_value,
    // result
    output logic        o_strobe,
    output logic [31:0] o_listed_value,
    output logic        o_is_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = orb_pkg::CAP_W;

    orb_pkg::t_state r_state;
    logic [IW-1:0]   r_newest;
    logic [IW-1:0]   r_oldest;
    logic [IW-1:0]   r_ptr;
    logic [IW-1:0]   r_k;
    logic            r_empty;
    logic [31:0]     r_value;
    logic [CW-1:0]   r_cap;
    logic [CW-1:0]   r_eff_cap;
    logic            r_pend;
    logic            r_pend_last;

    logic [IW-1:0]   w_adv_in;
    logic [IW-1:0]   w_adv_out;
    logic            w_cfg_wr;
    logic            w_last;
    logic [CW-1:0]   w_new_eff;
    logic            w_we;
    logic [IW-1:0]   w_waddr;

    // APB side
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == orb_pkg::REG_CAPACITY) ? {25'd0, r_cap} : 32'd0;

    // capacity clamp: 0 acts as 1, above DEPTH acts as DEPTH
    always_comb begin
        w_new_eff = pwdata[CW-1:0];
        if (w_new_eff == '0) begin
            w_new_eff = CW'(1);
        end else if (w_new_eff > CW'(DEPTH)) begin
            w_new_eff = CW'(DEPTH);
        end
    end

    // operand select for the shared index unit
    always_comb begin
        case (r_state)
            orb_pkg::ST_APP:  w_adv_in = r_newest;
            orb_pkg::ST_OLD:  w_adv_in = r_oldest;
            orb_pkg::ST_LIST: w_adv_in = r_ptr;
            default:          w_adv_in = r_ptr;
        endcase
    end

    orb_advance #(
        .IW (IW)
    ) u_advance (
        .i_index   (w_adv_in),
        .i_eff_cap (r_eff_cap),
        .o_next    (w_adv_out)
    );

    // newest entry of a list walk, or the walk has covered the whole store
    assign w_last = (r_ptr == r_newest) || (r_k == IW'(DEPTH - 1));

    // memory write on append: slot 0 when the ring was empty
    assign w_we    = (r_state == orb_pkg::ST_APP);
    assign w_waddr = r_empty ? '0 : w_adv_out;

    orb_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (r_state == orb_pkg::ST_LIST),
        .i_raddr (r_ptr),
        .o_rdata (o_listed_value)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orb_pkg::ST_IDLE;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_empty     <= 1'b1;
            r_cap       <= orb_pkg::CAP_RESET;
            r_eff_cap   <= CW'(DEPTH);
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            case (r_state)
                orb_pkg::ST_IDLE: begin
                    if (start) begin
                        case (i_action)
                            orb_pkg::ACT_APPEND: begin
                                r_value <= i_entry_value;
                                r_state <= orb_pkg::ST_APP;
                            end
                            orb_pkg::ACT_REMOVE: begin
                                if (!r_empty) begin
                                    if (r_newest == r_oldest) begin
                                        r_newest <= '0;
                                        r_oldest <= '0;
                                        r_empty  <= 1'b1;
                                    end else begin
                                        r_state <= orb_pkg::ST_OLD;
                                    end
                                end
                            end
                            orb_pkg::ACT_LIST: begin
                                if (!r_empty) begin
                                    r_ptr   <= r_oldest;
                                    r_k     <= '0;
                                    r_state <= orb_pkg::ST_LIST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                orb_pkg::ST_APP: begin
                    if (r_empty) begin
                        r_newest <= '0;
                        r_oldest <= '0;
                        r_empty  <= 1'b0;
                        r_state  <= orb_pkg::ST_IDLE;
                    end else begin
                        r_newest <= w_adv_out;
                        // full ring: oldest entry is overwritten
                        r_state  <= (w_adv_out == r_oldest) ? orb_pkg::ST_OLD
                                                            : orb_pkg::ST_IDLE;
                    end
                end
                orb_pkg::ST_OLD: begin
                    r_oldest <= w_adv_out;
                    r_state  <= orb_pkg::ST_IDLE;
                end
                orb_pkg::ST_LIST: begin
                    r_pend      <= 1'b1;
                    r_pend_last <= w_last;
                    if (w_last) begin
                        r_state <= orb_pkg::ST_IDLE;
                    end else begin
                        r_ptr <= w_adv_out;
                        r_k   <= r_k + IW'(1);
                    end
                end
                default: r_state <= orb_pkg::ST_IDLE;
            endcase

            // capacity write empties the ring
            if (w_cfg_wr && (paddr[2] == orb_pkg::REG_CAPACITY)) begin
                r_cap     <= pwdata[CW-1:0];
                r_eff_cap <= w_new_eff;
                r_newest  <= '0;
                r_oldest  <= '0;
                r_empty   <= 1'b1;
            end
        end
    end

    assign busy      = (r_state != orb_pkg::ST_IDLE);
    assign o_strobe  = r_pend;
    assign o_is_last = r_pend_last;

endmodule

/* sv/orb_advance.sv */
// Shared ring index unit: one step forward, wrapping at the effective capacity
module orb_advance #(
    parameter int IW = 6
) (
    input  logic [IW-1:0]             i_index,
    input  logic [orb_pkg::CAP_W-1:0] i_eff_cap,
    output logic [IW-1:0]             o_next
);

    logic [orb_pkg::CAP_W-1:0] w_sum;

    assign w_sum  = orb_pkg::CAP_W'(i_index) + orb_pkg::CAP_W'(1);
    assign o_next = (w_sum >= i_eff_cap) ? '0 : IW'(w_sum);

endmodule

/* sv/orb_store.sv */
// Entry memory: one write port, one registered read port
module orb_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
